// ----- rtl/mcit_pkg.sv -----
// ----------------------------------------------------------------------------
// mcit_pkg
// Shared types and constants of the interval timer bank.
// ----------------------------------------------------------------------------
package mcit_pkg;

	localparam int TIMERS_DEF = 8;
	localparam int MAX_FIRED  = 8;
	localparam int FCNT_W     = $clog2(MAX_FIRED + 1);

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_CONT  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_FIRED  = 2'd0,
		KIND_ACCEPT = 2'd1,
		KIND_REFUSE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMD,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	// one memory word per channel
	typedef struct packed {
		logic [31:0] reload;
		logic [31:0] deadline;
	} entry_t;

endpackage

// ----- rtl/mcit_mem.sv -----
// ----------------------------------------------------------------------------
// mcit_mem
// Channel store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mcit_mem #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  mcit_pkg::entry_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output mcit_pkg::entry_t rdata
);
	import mcit_pkg::*;

	entry_t mem [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/mcit_seq.sv -----
// ----------------------------------------------------------------------------
// mcit_seq
// Command sequencer and channel scan: tick counter, running flags, expiry
// check and reload write-back, result register.
// ----------------------------------------------------------------------------
module mcit_seq #(
	parameter int TIMERS = 8,
	parameter int AW     = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        op,
	input  logic [2:0]        timer_id,
	input  logic [31:0]       delay_ms,
	input  logic [31:0]       interval_ms,
	output logic              strobe,
	output logic [1:0]        kind,
	output logic [2:0]        which_timer,
	output logic              last,
	output logic              mem_we,
	output logic [AW-1:0]     mem_waddr,
	output mcit_pkg::entry_t  mem_wdata,
	output logic              mem_re,
	output logic [AW-1:0]     mem_raddr,
	input  mcit_pkg::entry_t  mem_rdata
);
	import mcit_pkg::*;

	state_t state_q, state_d;

	logic [31:0]       now_q;
	logic [TIMERS-1:0] running_q;
	op_t               op_q;
	logic [2:0]        id_q;
	logic [31:0]       delay_q;
	logic [31:0]       interval_q;

	logic [AW-1:0]     scan_q;
	logic              issue_done_q;
	logic              v_s1;
	logic [AW-1:0]     ch_s1;

	logic              pend_q;
	logic [AW-1:0]     pend_ch_q;
	logic [FCNT_W-1:0] fired_cnt_q;

	logic              res_valid_q;
	kind_t             res_kind_q;
	logic [2:0]        res_which_q;
	logic              res_last_q;

	logic              accept;
	logic              id_ok;
	logic [AW-1:0]     id_idx;
	logic [31:0]       diff;
	logic              hit;
	logic              report;

	logic              emit;
	kind_t             emit_kind;
	logic [2:0]        emit_which;
	logic              emit_last;
	logic              run_wr;
	logic [AW-1:0]     run_idx;
	logic              run_val;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign id_ok  = 32'(id_q) < 32'(TIMERS);
	assign id_idx = AW'(id_q);
	assign diff   = now_q - mem_rdata.deadline;
	assign hit    = v_s1 && running_q[ch_s1] && !diff[31];
	assign report = hit && (fired_cnt_q < FCNT_W'(MAX_FIRED));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (op_t'(op) == OP_TICK) ? ST_SCAN : ST_CMD;
				end
			end
			ST_CMD: state_d = ST_IDLE;
			ST_SCAN: begin
				if (v_s1 && ch_s1 == AW'(TIMERS - 1)) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of each state
	always_comb begin
		emit       = 1'b0;
		emit_kind  = KIND_ACCEPT;
		emit_which = id_q;
		emit_last  = 1'b1;
		run_wr     = 1'b0;
		run_idx    = id_idx;
		run_val    = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = ch_s1;
		mem_wdata  = '{reload: mem_rdata.reload, deadline: now_q + mem_rdata.reload};
		mem_re     = 1'b0;
		mem_raddr  = scan_q;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_CMD: begin
				emit = 1'b1;
				if (!id_ok) begin
					emit_kind = KIND_REFUSE;
				end else begin
					unique case (op_q)
						OP_START: begin
							if (delay_q == 32'd0 && interval_q == 32'd0) begin
								emit_kind = KIND_REFUSE;
							end else begin
								run_wr    = 1'b1;
								run_val   = 1'b1;
								mem_we    = 1'b1;
								mem_waddr = id_idx;
								mem_wdata = '{reload: interval_q, deadline: now_q + delay_q};
							end
						end
						OP_STOP: begin
							run_wr  = 1'b1;
							run_val = 1'b0;
						end
						OP_CONT: begin
							if (running_q[id_idx]) begin
								emit_kind = KIND_REFUSE;
							end else begin
								run_wr  = 1'b1;
								run_val = 1'b1;
							end
						end
						OP_TICK: begin
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCAN: begin
				mem_re = !issue_done_q;
				// a fired channel reloads or stops; the result lags by one hit
				if (hit) begin
					if (mem_rdata.reload == 32'd0) begin
						run_wr  = 1'b1;
						run_idx = ch_s1;
						run_val = 1'b0;
					end else begin
						mem_we = 1'b1;
					end
				end
				if (report && pend_q) begin
					emit       = 1'b1;
					emit_kind  = KIND_FIRED;
					emit_which = 3'(pend_ch_q);
					emit_last  = 1'b0;
				end
			end
			ST_FLUSH: begin
				emit       = pend_q;
				emit_kind  = KIND_FIRED;
				emit_which = 3'(pend_ch_q);
				emit_last  = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			now_q        <= '0;
			running_q    <= '0;
			scan_q       <= '0;
			issue_done_q <= 1'b0;
			v_s1         <= 1'b0;
			pend_q       <= 1'b0;
			fired_cnt_q  <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			v_s1        <= mem_re;
			res_valid_q <= emit;
			if (run_wr) begin
				running_q[run_idx] <= run_val;
			end
			if (accept && op_t'(op) == OP_TICK) begin
				now_q        <= now_q + 32'd1;
				scan_q       <= '0;
				issue_done_q <= 1'b0;
				pend_q       <= 1'b0;
				fired_cnt_q  <= '0;
			end
			if (mem_re) begin
				if (scan_q == AW'(TIMERS - 1)) begin
					issue_done_q <= 1'b1;
				end else begin
					scan_q <= scan_q + AW'(1);
				end
			end
			if (state_q == ST_SCAN && report) begin
				pend_q      <= 1'b1;
				fired_cnt_q <= fired_cnt_q + FCNT_W'(1);
			end
			if (state_q == ST_FLUSH) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= op_t'(op);
			id_q       <= timer_id;
			delay_q    <= delay_ms;
			interval_q <= interval_ms;
		end
		ch_s1 <= scan_q;
		if (state_q == ST_SCAN && report) begin
			pend_ch_q <= ch_s1;
		end
		res_kind_q  <= emit_kind;
		res_which_q <= emit_which;
		res_last_q  <= emit_last;
	end

	assign strobe      = res_valid_q;
	assign kind        = res_kind_q;
	assign which_timer = res_which_q;
	assign last        = res_last_q;

	a_cmd_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMD |=> res_valid_q && res_last_q)
		else $error("command did not give a final result");

	a_fired_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fired_cnt_q <= FCNT_W'(MAX_FIRED))
		else $error("fired count beyond limit");

	a_cmd_kind_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_kind_q != KIND_FIRED |-> res_last_q)
		else $error("command result without last");

	a_scan_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && state_q == ST_SCAN |-> v_s1 && mem_waddr == ch_s1)
		else $error("scan write-back off the evaluated channel");

	a_flush_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLUSH |=> !pend_q && state_q == ST_IDLE)
		else $error("pending result left after flush");

endmodule

// ----- rtl/multi_channel_interval_timer.sv -----
// ----------------------------------------------------------------------------
// multi_channel_interval_timer
// Bank of one-shot / periodic timer channels driven by a millisecond tick.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. A start, stop or
// continue holds busy while its command state decodes it, and gives one
// result. A tick holds busy through the scan and a flush state: the channel
// store has a single read port, so the scan reads one channel per cycle,
// checks it and writes its new deadline back in the cycle after the read, and
// the flush state then gives the final fired report. A command result
// shows on the result ports for one cycle with strobe high, in the cycle after
// the command is decoded; a fired report is held until the next fired channel
// is found or the scan ends, so that last can be marked. There is no
// backpressure, so capture every strobe. A tick reports at most eight fired
// channels, the last marked by last.
module multi_channel_interval_timer #(
	parameter int TIMERS = mcit_pkg::TIMERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [2:0]  timer_id,
	input  logic [31:0] delay_ms,
	input  logic [31:0] interval_ms,
	output logic        strobe,
	output logic [1:0]  kind,
	output logic [2:0]  which_timer,
	output logic        last
);
	import mcit_pkg::*;

	localparam int AW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	entry_t        mem_rdata;

	mcit_seq #(
		.TIMERS (TIMERS),
		.AW     (AW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.timer_id    (timer_id),
		.delay_ms    (delay_ms),
		.interval_ms (interval_ms),
		.strobe      (strobe),
		.kind        (kind),
		.which_timer (which_timer),
		.last        (last),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	mcit_mem #(
		.DEPTH (TIMERS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
